[hdl/xed_pkg.sv]
package xed_pkg;

    // number of bytes held back after an '&'
    localparam int HOLD_DEPTH = 4;
    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // characters that the decoder recognises
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LG   = 8'h67;
    localparam logic [7:0] CH_LL   = 8'h6C;
    localparam logic [7:0] CH_LM   = 8'h6D;
    localparam logic [7:0] CH_LO   = 8'h6F;
    localparam logic [7:0] CH_LP   = 8'h70;
    localparam logic [7:0] CH_LQ   = 8'h71;
    localparam logic [7:0] CH_LS   = 8'h73;
    localparam logic [7:0] CH_LT_T = 8'h74;
    localparam logic [7:0] CH_LU   = 8'h75;

    // one unit of output work: optional '&' plus held bytes, then an optional tail byte
    typedef struct packed {
        logic                       flush;
        logic [2:0]                 nbytes;
        logic [HOLD_DEPTH-1:0][7:0] bytes;
        logic                       tail_v;
        logic [7:0]                 tail;
        logic                       last;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AMP,
        ST_HELD,
        ST_TAIL
    } t_back_state;

    // digit value by the low 7 bits, two's complement, all ones for a non-digit
    function automatic logic [7:0] digit_val(input logic [7:0] c);
        logic [7:0] l;
        l = {1'b0, c[6:0]};
        if (l >= 8'h30 && l <= 8'h39) begin
            digit_val = l - 8'h30;
        end else if (l >= 8'h41 && l <= 8'h46) begin
            digit_val = l - 8'h37;
        end else if (l >= 8'h61 && l <= 8'h66) begin
            digit_val = l - 8'h57;
        end else begin
            digit_val = 8'hFF;
        end
    endfunction

endpackage

[hdl/xed_front.sv]
module xed_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    input  logic          i_q_full,
    output logic          o_job_valid,
    output xed_pkg::t_job o_job
);
    import xed_pkg::*;

    logic [2:0]                 r_count;
    logic [2:0]                 n_count;
    logic [HOLD_DEPTH-1:0][7:0] r_bytes;
    logic                       accept;
    logic                       pending;
    logic                       wr_en;
    logic [1:0]                 wr_idx;
    logic                       job_needed;
    logic [7:0]                 dec;
    logic [7:0]                 d1;
    logic [7:0]                 d2;
    logic [7:0]                 h1;
    logic [7:0]                 h2;

    assign accept  = push & ~i_q_full;
    assign full    = i_q_full;
    assign pending = (r_count != 3'd0);
    assign wr_idx  = 2'(r_count - 3'd1);

    // decode the pending entity from the held bytes, zero for no match
    always_comb begin
        d1  = digit_val(r_bytes[1]);
        d2  = digit_val(r_bytes[2]);
        h1  = digit_val(r_bytes[2]);
        h2  = digit_val(r_bytes[3]);
        dec = 8'h00;
        case (r_count)
            3'd3: begin
                if (r_bytes[0] == CH_LL && r_bytes[1] == CH_LT_T) begin
                    dec = CH_LT;
                end else if (r_bytes[0] == CH_LG && r_bytes[1] == CH_LT_T) begin
                    dec = CH_GT;
                end
            end
            3'd4: begin
                if (r_bytes[0] == CH_HASH) begin
                    dec = 8'({d1, 3'b000} + {d1, 1'b0} + {3'b000, d2});
                end else if (r_bytes[0] == CH_LA && r_bytes[1] == CH_LM
                             && r_bytes[2] == CH_LP) begin
                    dec = CH_AMP;
                end
            end
            3'd5: begin
                if (r_bytes[0] == CH_HASH && r_bytes[1] == CH_X) begin
                    dec = {h1[3:0], 4'b0000} | h2;
                end else if (r_bytes[0] == CH_LA && r_bytes[1] == CH_LP
                             && r_bytes[2] == CH_LO && r_bytes[3] == CH_LS) begin
                    dec = CH_APOS;
                end else if (r_bytes[0] == CH_LQ && r_bytes[1] == CH_LU
                             && r_bytes[2] == CH_LO && r_bytes[3] == CH_LT_T) begin
                    dec = CH_QUOT;
                end
            end
            default: dec = 8'h00;
        endcase
    end

    // classify the word and build its output job
    always_comb begin
        n_count      = r_count;
        wr_en        = 1'b0;
        job_needed   = 1'b1;
        o_job.flush  = 1'b0;
        o_job.nbytes = pending ? (r_count - 3'd1) : 3'd0;
        o_job.bytes  = r_bytes;
        o_job.tail_v = 1'b1;
        o_job.tail   = i_char;
        o_job.last   = i_last;
        if (i_char == CH_AMP) begin
            o_job.flush  = pending;
            o_job.tail_v = i_last;
            o_job.tail   = CH_AMP;
            job_needed   = pending | i_last;
            n_count      = i_last ? 3'd0 : 3'd1;
        end else if (pending && i_char == CH_SEMI) begin
            n_count = 3'd0;
            if (dec != 8'h00) begin
                o_job.tail = dec;
            end else begin
                o_job.flush = 1'b1;
            end
        end else if (pending && r_count < 3'd5) begin
            wr_en       = 1'b1;
            o_job.flush = 1'b1;
            job_needed  = i_last;
            n_count     = i_last ? 3'd0 : (r_count + 3'd1);
        end else if (pending) begin
            o_job.flush = 1'b1;
            n_count     = 3'd0;
        end
    end

    assign o_job_valid = accept & job_needed;

    // pending count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // held bytes
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_bytes[wr_idx] <= i_char;
        end
    end

endmodule

[hdl/xed_fifo.sv]
module xed_fifo #(
    parameter int DEPTH = xed_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xed_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output xed_pkg::t_job o_data,
    output logic          o_empty
);
    import xed_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[hdl/xed_back.sv]
module xed_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  xed_pkg::t_job i_job,
    output logic          o_q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    o_out_char,
    output logic          o_run_last,
    output logic          o_span_last
);
    import xed_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_job        r_job;
    logic [1:0]  r_idx;
    logic        advance;
    logic        final_word;
    logic        load;
    logic        held_end;

    assign held_end = ({1'b0, r_idx} == (r_job.nbytes - 3'd1));
    assign advance  = pop & (r_state != ST_IDLE);
    assign load     = ((r_state == ST_IDLE) | (advance & final_word)) & ~i_q_empty;
    assign o_q_pop  = load;

    // output word for the current state
    always_comb begin
        empty       = 1'b0;
        o_out_char  = r_job.tail;
        final_word  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                empty = 1'b1;
            end
            ST_AMP: begin
                o_out_char = CH_AMP;
                final_word = (r_job.nbytes == 3'd0) & ~r_job.tail_v;
            end
            ST_HELD: begin
                o_out_char = r_job.bytes[r_idx];
                final_word = held_end & ~r_job.tail_v;
            end
            ST_TAIL: begin
                final_word = 1'b1;
            end
            default: begin
                empty = 1'b1;
            end
        endcase
        o_run_last  = final_word;
        o_span_last = final_word & r_job.last;
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (load) begin
            n_state = i_job.flush ? ST_AMP : ST_TAIL;
        end else if (advance) begin
            case (r_state)
                ST_AMP: begin
                    if (r_job.nbytes != 3'd0) begin
                        n_state = ST_HELD;
                    end else if (r_job.tail_v) begin
                        n_state = ST_TAIL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_HELD: begin
                    if (!held_end) begin
                        n_state = ST_HELD;
                    end else if (r_job.tail_v) begin
                        n_state = ST_TAIL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_TAIL: n_state = ST_IDLE;
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // current job and held byte index
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
            r_idx <= 2'd0;
        end else if (advance && r_state == ST_HELD) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

[hdl/xml_entity_decoder.sv]
// XML character entity decoder.
// Input channel: one text word (i_in_char) with its end-of-span flag (i_in_last)
// is taken at each clock edge where push is high and full is low.
// Output channel: while empty is low, o_out_char, o_run_last and o_span_last show
// the oldest waiting word; it is taken at an edge where pop is high.
// Each input word gives zero to six output words. The front holds up to four
// bytes after an '&' and decodes the entity on ';' in the same cycle; its job
// goes into the queue (two entries by default). The back sends one word per cycle
// from its job while pop is high. With the back idle, a word that gives output is
// written into the queue and then into the back's job register before it shows.
// Input is taken at one word per cycle while the queue has room; output runs at
// one word per cycle while pop is high, with empty high while an idle back picks
// up a new job.
// A stalled receiver (pop low) holds the current output; the queue then fills and
// full rises, holding off the sender. Neither side loses or repeats a word.
// Reset (synchronous, active low) clears any pending entity, the queue and the
// back sequencer; no output is pending after reset.
module xml_entity_decoder #(
    parameter int QUEUE_DEPTH = xed_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    output logic       o_span_last
);
    import xed_pkg::*;

    t_job job_in;
    t_job job_out;
    logic job_valid;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // front: entity hold and classification
    xed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char      (i_in_char),
        .i_last      (i_in_last),
        .i_q_full    (q_full),
        .o_job_valid (job_valid),
        .o_job       (job_in)
    );

    // job queue between front and back
    xed_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    // back: byte sequencer
    xed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (job_out),
        .o_q_pop     (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last),
        .o_span_last (o_span_last)
    );

endmodule
